>>> rtl/ffia_pkg.sv
// Package for the FIFO free-ID allocator: sizes, status and action codes,
// and the control bundle broadcast to the cell chain. No dependencies.
`default_nettype none

package ffia_pkg;

    localparam int NUM_IDS = 64;
    // Identifier / count width: must hold the value NUM_IDS itself
    localparam int ID_W    = $clog2(NUM_IDS + 1);
    // Port identifier fields are 7 bits; compare in whichever is wider
    localparam int PORT_W  = 7;
    localparam int CMP_W   = (ID_W > PORT_W) ? ID_W : PORT_W;

    localparam logic       ACT_ALLOCATE  = 1'b0;
    localparam logic       ACT_RELEASE   = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        logic pop;        // head leaves, every entry moves one cell down
        logic push;       // write push_id at the cell that matches tail_pos
        t_id  tail_pos;   // cell id (index + 1) of the first empty entry
        t_id  push_id;
        logic mark_set;   // set in-use mark of mark_id
        logic mark_clr;   // clear in-use mark of mark_id
        t_id  mark_id;    // also the identifier whose mark is looked up
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/ffia_cell.sv
// One cell of the allocator chain: one free-list entry plus the in-use mark
// of the identifier equal to its own cell id. Depends on ffia_pkg.
`default_nettype none

module ffia_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire ffia_pkg::t_id       i_cell_id,
    input  wire ffia_pkg::t_cell_ctrl i_ctrl,
    input  wire ffia_pkg::t_id       i_next_id,
    output ffia_pkg::t_id            o_id,
    output logic                     o_mark,
    output logic                     o_hit
);
    import ffia_pkg::*;

    t_id  r_id,   n_id;
    logic r_mark, n_mark;
    logic own_mark;

    assign own_mark = (i_ctrl.mark_id == i_cell_id);

    always_comb begin
        n_id = r_id;
        if (i_ctrl.pop) begin
            n_id = i_next_id;
        end else if (i_ctrl.push && (i_ctrl.tail_pos == i_cell_id)) begin
            n_id = i_ctrl.push_id;
        end
    end

    always_comb begin
        n_mark = r_mark;
        if (own_mark && i_ctrl.mark_set) begin
            n_mark = 1'b1;
        end else if (own_mark && i_ctrl.mark_clr) begin
            n_mark = 1'b0;
        end
    end

    // Reset: entry k holds identifier k+1, no mark set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= i_cell_id;
            r_mark <= 1'b0;
        end else begin
            r_id   <= n_id;
            r_mark <= n_mark;
        end
    end

    assign o_id   = r_id;
    assign o_mark = r_mark;
    assign o_hit  = r_mark && own_mark;

endmodule

`default_nettype wire

>>> rtl/fifo_free_id_allocator_top.sv
// Top level of the FIFO free-ID allocator: request/response handshake,
// free count and result register around a chain of ffia_cell.
// Depends on ffia_pkg and ffia_cell.
`default_nettype none

// Hands out identifiers 1..NUM_IDS (64) oldest-free-first. One transaction
// in gives exactly one transaction out, in the cycle after acceptance; a new
// transaction is taken every cycle unless the result register is full and
// stalled. The free list lives in a row of NUM_IDS cells: cell 0 is the
// head, an allocate shifts every entry one cell towards the head, a release
// writes into the cell just past the last free entry. Each cell also keeps
// the in-use mark of one identifier, so the mark lookup is a compare in
// every cell and an OR across the row. Status codes: ok, no free identifier,
// identifier out of range (zero or above NUM_IDS), identifier not in use
// (double release, dropped). assigned_id is zero for anything but a
// successful allocate. After reset the block is ready at once; there is no
// clearing pass.

module fifo_free_id_allocator_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // request channel
    input  wire        i_valid,
    output logic       o_stall,
    input  wire        i_action,
    input  wire  [6:0] i_release_id,
    // response channel
    output logic       o_valid,
    input  wire        i_stall,
    output logic [1:0] o_status,
    output logic [6:0] o_assigned_id
);
    import ffia_pkg::*;

    // free identifier count, shared by pop/push control
    t_id              r_count,   n_count;
    logic             r_valid,   n_valid;
    logic [1:0]       r_status,  n_status;
    logic [6:0]       r_assigned, n_assigned;

    t_cell_ctrl       ctrl;
    t_id              cell_ids [NUM_IDS];
    logic [NUM_IDS-1:0] marks;
    logic [NUM_IDS-1:0] hits;

    logic             accept;
    logic             is_alloc;
    logic             list_empty;
    logic             list_full;
    logic [CMP_W-1:0] rid_w;
    logic [CMP_W-1:0] head_w;
    logic             range_bad;
    logic             in_use;
    logic             grant;
    logic             release_ok;

    // ---------------------------------------------------------------
    // Handshake: the result register frees up as it is taken
    // ---------------------------------------------------------------
    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    assign is_alloc   = (i_action == ACT_ALLOCATE);
    assign list_empty = (r_count == '0);
    assign list_full  = (r_count >= ID_W'(NUM_IDS));
    assign rid_w      = CMP_W'(i_release_id);
    assign head_w     = CMP_W'(cell_ids[0]);
    assign range_bad  = (rid_w == '0) || (rid_w > CMP_W'(NUM_IDS));
    assign in_use     = |hits;

    assign grant      = accept && is_alloc && !list_empty;
    assign release_ok = accept && !is_alloc && !range_bad && in_use && !list_full;

    // Broadcast to the cell row
    always_comb begin
        ctrl          = '0;
        ctrl.pop      = grant;
        ctrl.push     = release_ok;
        ctrl.tail_pos = r_count + 1'b1;
        ctrl.push_id  = ID_W'(rid_w);
        ctrl.mark_set = grant;
        ctrl.mark_clr = release_ok;
        // allocate marks the head identifier; release checks/clears its own
        ctrl.mark_id  = is_alloc ? cell_ids[0] : ID_W'(rid_w);
    end

    // ---------------------------------------------------------------
    // Cell chain: cell k holds free entry k and the mark of id k+1
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_IDS; k++) begin : g_cell
        t_id next_id;
        if (k < NUM_IDS - 1) begin : g_mid
            assign next_id = cell_ids[k+1];
        end else begin : g_last
            assign next_id = '0;
        end

        ffia_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (ID_W'(k + 1)),
            .i_ctrl    (ctrl),
            .i_next_id (next_id),
            .o_id      (cell_ids[k]),
            .o_mark    (marks[k]),
            .o_hit     (hits[k])
        );
    end

    // ---------------------------------------------------------------
    // Result and count update
    // ---------------------------------------------------------------
    always_comb begin
        n_count    = r_count;
        n_valid    = r_valid && i_stall;
        n_status   = r_status;
        n_assigned = r_assigned;
        if (grant) begin
            n_count = r_count - 1'b1;
        end else if (release_ok) begin
            n_count = r_count + 1'b1;
        end
        if (accept) begin
            n_valid    = 1'b1;
            n_assigned = '0;
            if (is_alloc) begin
                if (list_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status   = ST_OK;
                    n_assigned = head_w[6:0];
                end
            end else if (range_bad) begin
                n_status = ST_RANGE;
            end else if (!in_use || list_full) begin
                n_status = ST_NOT_IN_USE;
            end else begin
                n_status = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ID_W'(NUM_IDS);
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_assigned <= n_assigned;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_assigned_id = r_assigned;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ID_W'(NUM_IDS))
        else $error("free count above NUM_IDS");

    // every identifier is either on the free list or marked in use
    a_marks_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(marks) + int'(r_count)) == NUM_IDS)
        else $error("in-use marks disagree with free count");

    a_grant_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grant |=> (r_count == ID_W'($past(r_count) - 1'b1)) && (r_status == ST_OK))
        else $error("allocate did not pop the free list");

    a_release_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_ok |=> (r_count == ID_W'($past(r_count) + 1'b1)) && (r_assigned == '0))
        else $error("release did not append to the free list");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
